// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the timer block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define T8_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("timer check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define T8_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("timer check failed");

`endif

// ===== rtl/t8ctc_pkg.sv =====
// Types, codes and the prescaler table of the 8-bit prescaled timer.
package t8ctc_pkg;

  typedef enum logic [1:0] {
    ACT_TICK     = 2'd0,
    ACT_WR_COUNT = 2'd1,
    ACT_WR_OVF   = 2'd2,
    ACT_READ     = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    CFG_TIMER_MODE  = 3'd0,
    CFG_CLOCK_SEL   = 3'd1,
    CFG_OVF_IRQ_EN  = 3'd2,
    CFG_CMP_IRQ_EN  = 3'd3,
    CFG_CMP_VALUE   = 3'd4
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned PrescW   = 10;
  localparam int unsigned DivW     = PrescW + 1;

  typedef struct packed {
    action_e       action;
    logic [15:0]   write_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  counter_value;
    logic [15:0] overflow_total;
    logic [23:0] extended_ticks;
    logic        overflow_irq;
    logic        compare_irq;
  } out_item_t;

  typedef struct packed {
    logic       timer_mode;
    logic [2:0] clock_select;
    logic       overflow_irq_enable;
    logic       compare_irq_enable;
    logic [7:0] compare_value;
  } cfg_t;

  typedef struct packed {
    logic [7:0]        count;
    logic [PrescW-1:0] prescale;
    logic [15:0]       overflows;
  } state_t;

  // Prescaler divisor per clock select; zero means stopped.
  function automatic logic [DivW-1:0] divisor_of(input logic [2:0] sel);
    logic [DivW-1:0] div;
    case (sel)
      3'd1:    div = DivW'(1);
      3'd2:    div = DivW'(8);
      3'd3:    div = DivW'(64);
      3'd4:    div = DivW'(256);
      3'd5:    div = DivW'(1024);
      default: div = '0;
    endcase
    return div;
  endfunction

endpackage

// ===== rtl/t8ctc_core.sv =====
// Next-state and result logic for one transaction of the timer.
module t8ctc_core (
  input  t8ctc_pkg::cfg_t      cfg_i,
  input  t8ctc_pkg::state_t    state_i,
  input  t8ctc_pkg::in_item_t  item_i,
  output t8ctc_pkg::state_t    state_o,
  output t8ctc_pkg::out_item_t result_o
);
  import t8ctc_pkg::*;

  logic [DivW-1:0] div;
  logic [DivW-1:0] presc_inc;
  logic            running;
  logic            count_step;
  logic            match;
  logic            wrap;
  logic            ovf_pulse;
  logic            cmp_pulse;

  assign div       = divisor_of(cfg_i.clock_select);
  assign running   = (div != '0);
  assign presc_inc = {1'b0, state_i.prescale} + DivW'(1);
  assign match     = (state_i.count == cfg_i.compare_value);
  assign wrap      = (state_i.count == 8'hFF);

  always_comb begin
    state_o    = state_i;
    count_step = 1'b0;
    ovf_pulse  = 1'b0;
    cmp_pulse  = 1'b0;
    unique case (item_i.action)
      ACT_TICK: begin
        if (running) begin
          if (presc_inc >= div) begin
            count_step     = 1'b1;
            state_o.prescale = '0;
          end else begin
            state_o.prescale = presc_inc[PrescW-1:0];
          end
        end
        if (count_step) begin
          if (cfg_i.timer_mode && match) begin
            state_o.count = '0;
          end else begin
            state_o.count = state_i.count + 8'd1;
          end
          cmp_pulse = match && cfg_i.compare_irq_enable;
          if (wrap && cfg_i.overflow_irq_enable) begin
            ovf_pulse         = 1'b1;
            state_o.overflows = state_i.overflows + 16'd1;
          end
        end
      end
      ACT_WR_COUNT: state_o.count     = item_i.write_value[7:0];
      ACT_WR_OVF:   state_o.overflows = item_i.write_value;
      ACT_READ:     state_o           = state_i;
      default:      state_o           = state_i;
    endcase
  end

  always_comb begin
    result_o.counter_value  = state_o.count;
    result_o.overflow_total = state_o.overflows;
    result_o.extended_ticks = {state_o.overflows, state_o.count};
    result_o.overflow_irq   = ovf_pulse;
    result_o.compare_irq    = cmp_pulse;
  end

endmodule

// ===== rtl/timer8_prescaled_ctc_with_overflow_count.sv =====
// Top level of the 8-bit prescaled timer with CTC mode and overflow count.
// Output: the result of an accepted transaction is held in the output register result_q.
// Throughput: one transaction per cycle; the output register refills in the
//   cycle its result is taken, so ready only drops while a result is stalled.
// Reset: counter, prescaler, overflow count, configuration and output valid
//   all clear; the timer comes up stopped in normal mode.
module timer8_prescaled_ctc_with_overflow_count (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration writes
  input  logic                                cfg_we_i,
  input  logic [t8ctc_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [t8ctc_pkg::CfgDataW-1:0]      cfg_wdata_i,
  // input transactions
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  t8ctc_pkg::in_item_t                 in_item_i,
  // result transactions
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output t8ctc_pkg::out_item_t                out_item_o
);
  import t8ctc_pkg::*;

  cfg_t      cfg_q;
  state_t    state_q, state_d;
  out_item_t result_d, result_q;
  logic      out_valid_q;
  logic      in_fire;

  // Single output register: free when empty or being drained this cycle.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // Configuration registers; bits above a register's width are dropped,
  // unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_TIMER_MODE: cfg_q.timer_mode          <= cfg_wdata_i[0];
        CFG_CLOCK_SEL:  cfg_q.clock_select        <= cfg_wdata_i[2:0];
        CFG_OVF_IRQ_EN: cfg_q.overflow_irq_enable <= cfg_wdata_i[0];
        CFG_CMP_IRQ_EN: cfg_q.compare_irq_enable  <= cfg_wdata_i[0];
        CFG_CMP_VALUE:  cfg_q.compare_value       <= cfg_wdata_i;
        default:        cfg_q                     <= cfg_q;
      endcase
    end
  end

  // All per-transaction work: prescaler, count step, compare, wrap.
  t8ctc_core u_core (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .item_i   (in_item_i),
    .state_o  (state_d),
    .result_o (result_d)
  );

  // Timer state advances only on an accepted transaction, so the next
  // transaction in the following cycle already sees the updated count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload, no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = result_q;

endmodule

// ===== rtl/t8ctc_checker.sv =====
// Port-level checker for the timer, bound to the top level.
`include "assert_macros.svh"

module t8ctc_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input t8ctc_pkg::in_item_t  in_item_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input t8ctc_pkg::out_item_t out_item_o
);
  import t8ctc_pkg::*;

  logic in_fire;
  logic pulse_free;
  logic ext_ok;

  assign in_fire    = in_valid_i && in_ready_o;
  assign pulse_free = !out_item_o.overflow_irq && !out_item_o.compare_irq;
  assign ext_ok     = (out_item_o.extended_ticks ==
                       {out_item_o.overflow_total, out_item_o.counter_value});

  // A stalled result holds.
  `T8_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_item_o))
  // Every accepted transaction produces a result next cycle.
  `T8_ASSERT_NEXT(a_in_to_out, in_fire, out_valid_o)
  // Only ticks raise interrupt pulses.
  `T8_ASSERT_NEXT(a_pulse_tick, in_fire && (in_item_i.action != ACT_TICK), pulse_free)
  // Extended ticks are the overflow count above the counter.
  `T8_ASSERT(a_ext_ticks, out_valid_o, ext_ok)
  // An overflow always leaves the counter at zero.
  `T8_ASSERT(a_ovf_zero, out_valid_o && out_item_o.overflow_irq, out_item_o.counter_value == 8'd0)

endmodule

bind timer8_prescaled_ctc_with_overflow_count t8ctc_checker u_t8ctc_checker (.*);
